[rtl/core/fisheye_forward_projection_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the fisheye projection core
// Short forms for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef FISHEYE_FORWARD_PROJECTION_ASSERT_SVH
`define FISHEYE_FORWARD_PROJECTION_ASSERT_SVH

// same-cycle implication
`define FPJ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FPJ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fpj_pkg.sv]
// ----------------------------------------------------------------------------
// fpj_pkg
// Shared types, register indexes and constants of the fisheye projection core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpj_pkg;

    localparam int CFG_IDX_W    = 8;
    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_STEPS = 32;
    localparam int DIV_STEPS    = 31;
    localparam int CORDIC_LAST  = CORDIC_STEPS + 2;

    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_K1  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_K2  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_K3  = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_K4  = 8'd7;

    localparam logic [30:0] FOCAL_RESET = 31'd65536;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
    localparam logic signed [63:0] S32_MAX     = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN     = -64'sd2147483648;
    localparam logic [4:0] SH_Q30 = 5'd30;
    localparam logic [4:0] SH_Q24 = 5'd24;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } fpj_point_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
        fpj_point_t  pt;
    } fpj_sqrt_t;

    typedef struct packed {
        logic               half_turn;
        logic               zero;
        logic [5:0]         nsh;
        logic signed [63:0] vx;
        logic signed [63:0] vy;
        logic signed [31:0] ang;
        logic [31:0]        rho;
        logic               xneg;
        logic               yneg;
        logic               xlsb;
        logic               ylsb;
        logic [32:0]        rem_x;
        logic [32:0]        rem_y;
        logic [30:0]        q_x;
        logic [30:0]        q_y;
    } fpj_cordic_t;

    // data riding beside the multiplier chain
    typedef struct packed {
        logic signed [33:0] theta;
        logic signed [35:0] t2;
        logic signed [32:0] fc;
        logic signed [32:0] fs;
    } fpj_side_t;

    // round(atan(2^-i) * 2^30)
    function automatic logic [29:0] atan_entry(input logic [4:0] i);
        logic [29:0] e;
        case (i)
            5'd0:  e = 30'd843314857;
            5'd1:  e = 30'd497837829;
            5'd2:  e = 30'd263043837;
            5'd3:  e = 30'd133525159;
            5'd4:  e = 30'd67021687;
            5'd5:  e = 30'd33543516;
            5'd6:  e = 30'd16775851;
            5'd7:  e = 30'd8388437;
            5'd8:  e = 30'd4194283;
            5'd9:  e = 30'd2097149;
            5'd10: e = 30'd1048576;
            5'd11: e = 30'd524288;
            5'd12: e = 30'd262144;
            5'd13: e = 30'd131072;
            5'd14: e = 30'd65536;
            5'd15: e = 30'd32768;
            5'd16: e = 30'd16384;
            5'd17: e = 30'd8192;
            5'd18: e = 30'd4096;
            5'd19: e = 30'd2048;
            5'd20: e = 30'd1024;
            5'd21: e = 30'd512;
            5'd22: e = 30'd256;
            5'd23: e = 30'd128;
            5'd24: e = 30'd64;
            5'd25: e = 30'd32;
            5'd26: e = 30'd16;
            5'd27: e = 30'd8;
            5'd28: e = 30'd4;
            5'd29: e = 30'd2;
            default: e = 30'd1;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

[rtl/core/fisheye_forward_projection.sv]
// ----------------------------------------------------------------------------
// fisheye_forward_projection
// Fisheye (equidistant polynomial) projection of camera points to pixels.
// ----------------------------------------------------------------------------
// Takes one camera-frame point per cycle and returns one pixel per point,
// in order. The pipeline is fully pipelined: the latency is set by the
// radial square root (one root bit per stage, 34 stages), the angle CORDIC
// with its side-by-side dividers (36 stages) and a chain of seven 4-stage
// 64-bit multipliers plus an output register.
// Throughput is one item per clock; the whole pipe holds while the output
// register carries an item that the sink has not taken.
// Configuration writes take effect immediately; write them only while the
// pipe is empty. Addresses beyond the eight registers are ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fisheye_forward_projection import fpj_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [95:0]          s_tdata,   // point_x, point_y, point_z
    // result items
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [63:0]               m_tdata,   // pixel_u, pixel_v
    output logic                      m_tuser,   // saturated
    // register writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [31:0]          cfg_wdata
);

    // ---------------- configuration registers ----------------
    logic [30:0]        focal_x_reg, focal_y_reg;
    logic signed [31:0] center_x_reg, center_y_reg;
    logic signed [31:0] coef_k1_reg, coef_k2_reg, coef_k3_reg, coef_k4_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg  <= FOCAL_RESET;
            focal_y_reg  <= FOCAL_RESET;
            center_x_reg <= '0;
            center_y_reg <= '0;
            coef_k1_reg  <= '0;
            coef_k2_reg  <= '0;
            coef_k3_reg  <= '0;
            coef_k4_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                REG_FOCAL_X:  focal_x_reg  <= cfg_wdata[30:0];
                REG_FOCAL_Y:  focal_y_reg  <= cfg_wdata[30:0];
                REG_CENTER_X: center_x_reg <= cfg_wdata;
                REG_CENTER_Y: center_y_reg <= cfg_wdata;
                REG_COEF_K1:  coef_k1_reg  <= cfg_wdata;
                REG_COEF_K2:  coef_k2_reg  <= cfg_wdata;
                REG_COEF_K3:  coef_k3_reg  <= cfg_wdata;
                REG_COEF_K4:  coef_k4_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // one enable for every stage: advance unless the output holds an
    // item the sink has not taken
    logic en;
    logic m_tvalid_reg;
    logic [63:0] m_tdata_reg;
    logic m_tuser_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    fpj_point_t in_pt;
    assign in_pt.x = s_tdata[31:0];
    assign in_pt.y = s_tdata[63:32];
    assign in_pt.z = s_tdata[95:64];

    // ---------------- radial distance ----------------
    logic        sq_valid;
    logic [31:0] sq_rho;
    fpj_point_t  sq_pt;

    fpj_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid && s_tready),
        .in_pt     (in_pt),
        .out_valid (sq_valid),
        .rho       (sq_rho),
        .out_pt    (sq_pt)
    );

    // ---------------- incidence angle, cos/sin of azimuth ----------------
    logic               an_valid;
    logic signed [33:0] an_theta;
    logic signed [31:0] an_cos, an_sin;

    fpj_angle u_angle (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_rho    (sq_rho),
        .in_pt     (sq_pt),
        .out_valid (an_valid),
        .theta     (an_theta),
        .cos_q     (an_cos),
        .sin_q     (an_sin)
    );

    // ---------------- multiplier chain ----------------
    // 0: t2 = theta^2           (6,7 in parallel: fx*c, fy*s)
    // 1..3: Horner on k4..k1    4: p = a*t2
    // 5: r = theta + theta*p    8,9: u, v
    logic signed [63:0] k1_w, k2_w, k3_w, k4_w, cx_w, cy_w, theta_w;
    assign k1_w    = {{32{coef_k1_reg[31]}}, coef_k1_reg};
    assign k2_w    = {{32{coef_k2_reg[31]}}, coef_k2_reg};
    assign k3_w    = {{32{coef_k3_reg[31]}}, coef_k3_reg};
    assign k4_w    = {{32{coef_k4_reg[31]}}, coef_k4_reg};
    assign cx_w    = {{32{center_x_reg[31]}}, center_x_reg};
    assign cy_w    = {{32{center_y_reg[31]}}, center_y_reg};
    assign theta_w = {{30{an_theta[33]}}, an_theta};

    fpj_side_t side_a, side0, side1_in, side1, side2, side3, side4, side5;
    logic v0, v1, v2, v3, v4, v5, v8;
    logic signed [63:0] r0, r1, r2, r3, r4, r5, r6, r7, r8, r9;

    assign side_a = '{theta: an_theta, t2: 36'sd0, fc: 33'sd0, fs: 33'sd0};

    fpj_mul u_mul_t2 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(an_valid),
        .op_a(theta_w), .op_b(theta_w), .addend(64'sd0), .shift(SH_Q30),
        .side_in(side_a), .out_valid(v0), .result(r0), .side_out(side0)
    );

    fpj_mul u_mul_fc (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(an_valid),
        .op_a($signed({33'd0, focal_x_reg})), .op_b({{32{an_cos[31]}}, an_cos}),
        .addend(64'sd0), .shift(SH_Q30),
        .side_in(side_a), .out_valid(), .result(r6), .side_out()
    );

    fpj_mul u_mul_fs (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(an_valid),
        .op_a($signed({33'd0, focal_y_reg})), .op_b({{32{an_sin[31]}}, an_sin}),
        .addend(64'sd0), .shift(SH_Q30),
        .side_in(side_a), .out_valid(), .result(r7), .side_out()
    );

    assign side1_in = '{theta: side0.theta, t2: r0[35:0], fc: r6[32:0], fs: r7[32:0]};

    fpj_mul u_mul_h1 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v0),
        .op_a(k4_w), .op_b(r0), .addend(k3_w), .shift(SH_Q30),
        .side_in(side1_in), .out_valid(v1), .result(r1), .side_out(side1)
    );

    fpj_mul u_mul_h2 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v1),
        .op_a(r1), .op_b({{28{side1.t2[35]}}, side1.t2}), .addend(k2_w),
        .shift(SH_Q30),
        .side_in(side1), .out_valid(v2), .result(r2), .side_out(side2)
    );

    fpj_mul u_mul_h3 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v2),
        .op_a(r2), .op_b({{28{side2.t2[35]}}, side2.t2}), .addend(k1_w),
        .shift(SH_Q30),
        .side_in(side2), .out_valid(v3), .result(r3), .side_out(side3)
    );

    fpj_mul u_mul_p (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v3),
        .op_a(r3), .op_b({{28{side3.t2[35]}}, side3.t2}), .addend(64'sd0),
        .shift(SH_Q30),
        .side_in(side3), .out_valid(v4), .result(r4), .side_out(side4)
    );

    fpj_mul u_mul_r (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v4),
        .op_a({{30{side4.theta[33]}}, side4.theta}), .op_b(r4),
        .addend({{30{side4.theta[33]}}, side4.theta}), .shift(SH_Q24),
        .side_in(side4), .out_valid(v5), .result(r5), .side_out(side5)
    );

    fpj_mul u_mul_u (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v5),
        .op_a({{31{side5.fc[32]}}, side5.fc}), .op_b(r5), .addend(cx_w),
        .shift(SH_Q30),
        .side_in(side5), .out_valid(v8), .result(r8), .side_out()
    );

    fpj_mul u_mul_v (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v5),
        .op_a({{31{side5.fs[32]}}, side5.fs}), .op_b(r5), .addend(cy_w),
        .shift(SH_Q30),
        .side_in(side5), .out_valid(), .result(r9), .side_out()
    );

    // ---------------- clip and output register ----------------
    logic u_hi, u_lo, v_hi, v_lo;
    logic [31:0] u_clip, v_clip;

    assign u_hi = r8 > S32_MAX;
    assign u_lo = r8 < S32_MIN;
    assign v_hi = r9 > S32_MAX;
    assign v_lo = r9 < S32_MIN;

    always_comb begin
        u_clip = r8[31:0];
        if (u_hi) u_clip = S32_MAX[31:0];
        if (u_lo) u_clip = S32_MIN[31:0];
        v_clip = r9[31:0];
        if (v_hi) v_clip = S32_MAX[31:0];
        if (v_lo) v_clip = S32_MIN[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= v8;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {v_clip, u_clip};
            m_tuser_reg <= u_hi | u_lo | v_hi | v_lo;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

[rtl/core/fpj_mul.sv]
// ----------------------------------------------------------------------------
// fpj_mul
// Pipelined signed 64x64 multiply, truncating shift, saturate, add.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpj_mul import fpj_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic signed [63:0] op_a,
    input  wire logic signed [63:0] op_b,
    input  wire logic signed [63:0] addend,
    input  wire logic [4:0]         shift,
    input  wire fpj_side_t          side_in,
    output logic                    out_valid,
    output logic signed [63:0]      result,
    output fpj_side_t               side_out
);

    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic neg0_reg, neg1_reg, neg2_reg;
    logic [63:0] ma0_reg, mb0_reg;
    logic [63:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0] prod2_reg;
    logic signed [63:0] add0_reg, add1_reg, add2_reg;
    fpj_side_t side0_reg, side1_reg, side2_reg, side3_reg;
    logic signed [63:0] result_reg;

    logic [127:0] prod_next;
    logic [127:0] shifted;
    logic [62:0]  mag63;
    logic signed [63:0] sval;
    logic signed [63:0] result_next;

    assign prod_next = {64'd0, p00_reg}
                     + ({64'd0, p01_reg} << 32)
                     + ({64'd0, p10_reg} << 32)
                     + ({p11_reg, 64'd0});

    always_comb begin
        shifted     = prod2_reg >> shift;
        mag63       = (|shifted[127:63]) ? {63{1'b1}} : shifted[62:0];
        sval        = $signed({1'b0, mag63});
        result_next = add2_reg + (neg2_reg ? -sval : sval);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg0_reg   <= op_a[63] ^ op_b[63];
            ma0_reg    <= op_a[63] ? (~op_a + 64'd1) : op_a;
            mb0_reg    <= op_b[63] ? (~op_b + 64'd1) : op_b;
            add0_reg   <= addend;
            side0_reg  <= side_in;

            neg1_reg   <= neg0_reg;
            p00_reg    <= 64'(ma0_reg[31:0])  * 64'(mb0_reg[31:0]);
            p01_reg    <= 64'(ma0_reg[31:0])  * 64'(mb0_reg[63:32]);
            p10_reg    <= 64'(ma0_reg[63:32]) * 64'(mb0_reg[31:0]);
            p11_reg    <= 64'(ma0_reg[63:32]) * 64'(mb0_reg[63:32]);
            add1_reg   <= add0_reg;
            side1_reg  <= side0_reg;

            neg2_reg   <= neg1_reg;
            prod2_reg  <= prod_next;
            add2_reg   <= add1_reg;
            side2_reg  <= side1_reg;

            result_reg <= result_next;
            side3_reg  <= side2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign result    = result_reg;
    assign side_out  = side3_reg;

endmodule

`default_nettype wire

[rtl/core/fpj_isqrt.sv]
// ----------------------------------------------------------------------------
// fpj_isqrt
// Radial distance: squares, sum, then one root bit per pipeline stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpj_isqrt import fpj_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  wire fpj_point_t in_pt,
    output logic            out_valid,
    output logic [31:0]     rho,
    output fpj_point_t      out_pt
);

    logic        vq_reg;
    logic [63:0] sqx_reg, sqy_reg;
    fpj_point_t  ptq_reg;
    logic [31:0] mx, my;

    logic      vld_reg  [0:SQRT_STEPS];
    fpj_sqrt_t st_reg   [0:SQRT_STEPS];
    fpj_sqrt_t st_next  [0:SQRT_STEPS];

    assign mx = in_pt.x[31] ? (~in_pt.x + 32'd1) : in_pt.x;
    assign my = in_pt.y[31] ? (~in_pt.y + 32'd1) : in_pt.y;

    always_comb begin
        st_next[0].rem  = sqx_reg + sqy_reg;
        st_next[0].root = 64'd0;
        st_next[0].pt   = ptq_reg;
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        always_comb begin
            st_next[k+1] = st_reg[k];
            if (st_reg[k].rem >= st_reg[k].root + BIT) begin
                st_next[k+1].rem  = st_reg[k].rem - (st_reg[k].root + BIT);
                st_next[k+1].root = (st_reg[k].root >> 1) + BIT;
            end else begin
                st_next[k+1].root = st_reg[k].root >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vq_reg <= 1'b0;
            for (int k = 0; k <= SQRT_STEPS; k++) vld_reg[k] <= 1'b0;
        end else if (en) begin
            vq_reg     <= in_valid;
            vld_reg[0] <= vq_reg;
            for (int k = 1; k <= SQRT_STEPS; k++) vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg <= 64'(mx) * 64'(mx);
            sqy_reg <= 64'(my) * 64'(my);
            ptq_reg <= in_pt;
            for (int k = 0; k <= SQRT_STEPS; k++) st_reg[k] <= st_next[k];
        end
    end

    assign out_valid = vld_reg[SQRT_STEPS];
    assign rho       = st_reg[SQRT_STEPS].root[31:0];
    assign out_pt    = st_reg[SQRT_STEPS].pt;

endmodule

`default_nettype wire

[rtl/core/fpj_angle.sv]
// ----------------------------------------------------------------------------
// fpj_angle
// Incidence angle by vectoring CORDIC, with the x/rho and y/rho dividers
// running one quotient bit per stage alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpj_angle import fpj_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [31:0]   in_rho,
    input  wire fpj_point_t    in_pt,
    output logic               out_valid,
    output logic signed [33:0] theta,
    output logic signed [31:0] cos_q,
    output logic signed [31:0] sin_q
);

    logic        vld_reg [0:CORDIC_LAST];
    fpj_cordic_t st_reg  [0:CORDIC_LAST];
    fpj_cordic_t st_next [0:CORDIC_LAST];

    logic               vout_reg;
    logic signed [33:0] theta_reg;
    logic signed [31:0] cos_reg, sin_reg;

    logic [31:0] mx, my;
    logic [32:0] vmax;
    logic signed [63:0] zext;

    function automatic logic [5:0] msb_pos(input logic [32:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int b = 0; b < 33; b++) begin
            if (v[b]) p = 6'(b);
        end
        return p;
    endfunction

    assign mx   = in_pt.x[31] ? (~in_pt.x + 32'd1) : in_pt.x;
    assign my   = in_pt.y[31] ? (~in_pt.y + 32'd1) : in_pt.y;
    assign zext = {{32{in_pt.z[31]}}, in_pt.z};

    // swap into the right half plane when z is behind the camera
    always_comb begin
        st_next[0]           = '0;
        st_next[0].half_turn = in_pt.z[31];
        st_next[0].zero      = (in_pt.z == 32'sd0) && (in_rho == 32'd0);
        st_next[0].vx        = in_pt.z[31] ? $signed({32'd0, in_rho}) : zext;
        st_next[0].vy        = in_pt.z[31] ? -zext : $signed({32'd0, in_rho});
        st_next[0].rho       = in_rho;
        st_next[0].xneg      = in_pt.x[31];
        st_next[0].yneg      = in_pt.y[31];
        st_next[0].xlsb      = mx[0];
        st_next[0].ylsb      = my[0];
        st_next[0].rem_x     = {2'b00, mx[31:1]};
        st_next[0].rem_y     = {2'b00, my[31:1]};
    end

    // normalize so the larger leg lies in [2^59, 2^60)
    assign vmax = (st_reg[0].vx[32:0] > st_reg[0].vy[32:0]) ?
                  st_reg[0].vx[32:0] : st_reg[0].vy[32:0];

    always_comb begin
        st_next[1]     = st_reg[0];
        st_next[1].nsh = 6'd59 - msb_pos(vmax);
        st_next[2]     = st_reg[1];
        st_next[2].vx  = st_reg[1].vx <<< st_reg[1].nsh;
        st_next[2].vy  = st_reg[1].vy <<< st_reg[1].nsh;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        localparam bit DIV_ON = (i < DIV_STEPS);
        localparam bit FIRST  = (i == 0);
        localparam int QB     = DIV_ON ? (DIV_STEPS - 1 - i) : 0;
        fpj_cordic_t cur;
        logic signed [63:0] xsh, ysh;
        logic signed [31:0] ea;
        logic [32:0] rsx, rsy;

        assign cur = st_reg[2+i];
        assign xsh = $signed(cur.vx) >>> i;
        assign ysh = $signed(cur.vy) >>> i;
        assign ea  = $signed({2'b00, atan_entry(5'(i))});
        assign rsx = {cur.rem_x[31:0], FIRST ? cur.xlsb : 1'b0};
        assign rsy = {cur.rem_y[31:0], FIRST ? cur.ylsb : 1'b0};

        always_comb begin
            st_next[3+i] = cur;
            if (!cur.vy[63]) begin
                st_next[3+i].vx  = cur.vx + ysh;
                st_next[3+i].vy  = cur.vy - xsh;
                st_next[3+i].ang = cur.ang + ea;
            end else begin
                st_next[3+i].vx  = cur.vx - ysh;
                st_next[3+i].vy  = cur.vy + xsh;
                st_next[3+i].ang = cur.ang - ea;
            end
            if (DIV_ON) begin
                if (rsx >= {1'b0, cur.rho}) begin
                    st_next[3+i].rem_x   = rsx - {1'b0, cur.rho};
                    st_next[3+i].q_x[QB] = 1'b1;
                end else begin
                    st_next[3+i].rem_x   = rsx;
                    st_next[3+i].q_x[QB] = 1'b0;
                end
                if (rsy >= {1'b0, cur.rho}) begin
                    st_next[3+i].rem_y   = rsy - {1'b0, cur.rho};
                    st_next[3+i].q_y[QB] = 1'b1;
                end else begin
                    st_next[3+i].rem_y   = rsy;
                    st_next[3+i].q_y[QB] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vout_reg <= 1'b0;
            for (int k = 0; k <= CORDIC_LAST; k++) vld_reg[k] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= CORDIC_LAST; k++) vld_reg[k] <= vld_reg[k-1];
            vout_reg <= vld_reg[CORDIC_LAST];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= CORDIC_LAST; k++) st_reg[k] <= st_next[k];
            if (st_reg[CORDIC_LAST].zero) begin
                theta_reg <= 34'sd0;
            end else begin
                theta_reg <= (st_reg[CORDIC_LAST].half_turn ? HALF_PI_Q30 : 34'sd0)
                           + {{2{st_reg[CORDIC_LAST].ang[31]}}, st_reg[CORDIC_LAST].ang};
            end
            if (st_reg[CORDIC_LAST].rho == 32'd0) begin
                cos_reg <= ONE_Q30;
                sin_reg <= 32'sd0;
            end else begin
                cos_reg <= st_reg[CORDIC_LAST].xneg ? -$signed({1'b0, st_reg[CORDIC_LAST].q_x})
                                                    : $signed({1'b0, st_reg[CORDIC_LAST].q_x});
                sin_reg <= st_reg[CORDIC_LAST].yneg ? -$signed({1'b0, st_reg[CORDIC_LAST].q_y})
                                                    : $signed({1'b0, st_reg[CORDIC_LAST].q_y});
            end
        end
    end

    assign out_valid = vout_reg;
    assign theta     = theta_reg;
    assign cos_q     = cos_reg;
    assign sin_q     = sin_reg;

endmodule

`default_nettype wire

[rtl/core/fpj_check.sv]
// ----------------------------------------------------------------------------
// fpj_check
// Port-level checks of the fisheye projection core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fisheye_forward_projection_assert.svh"

module fpj_check import fpj_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [95:0]          s_tdata,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [63:0]          m_tdata,
    input wire logic                 m_tuser,
    input wire logic                 cfg_valid,
    input wire logic                 cfg_ready,
    input wire logic [CFG_IDX_W-1:0] cfg_addr,
    input wire logic [31:0]          cfg_wdata
);

    `FPJ_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result item dropped while stalled")
    `FPJ_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result item changed")
    `FPJ_ASSERT_IMP(a_in_free, !m_tvalid || m_tready, s_tready && cfg_ready, "input stalled with free output")
    `FPJ_ASSERT_IMP(a_sat_limit, m_tvalid && m_tuser, (m_tdata[31:0] == 32'h7FFFFFFF) || (m_tdata[31:0] == 32'h80000000) || (m_tdata[63:32] == 32'h7FFFFFFF) || (m_tdata[63:32] == 32'h80000000), "saturated without a clipped coordinate")

endmodule

bind fisheye_forward_projection fpj_check u_fpj_check (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
);

`default_nettype wire

[bench/tb_fisheye_forward_projection.sv]
// ----------------------------------------------------------------------------
// tb_fisheye_forward_projection
// Self-checking bench for the fisheye point-to-pixel projection core.
// ----------------------------------------------------------------------------
// Points stream in through the s_ side with random gaps, and pixels are taken
// on the m_ side with random stalls. A scoreboard class predicts each pixel in
// exact fixed point (radial root, angle CORDIC, distortion polynomial, focal
// scaling, clipping) and checks the results in order. The calibration
// registers are rewritten between phases while the pipe is empty: reset
// values, a typical lens, the register extremes, random settings and a closing lens.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class pixel_scoreboard;

    typedef struct {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic               sat;
    } pixel_t;

    // calibration copy, same meaning as the block registers
    longint focal_x, focal_y, center_x, center_y;
    longint k1, k2, k3, k4;
    pixel_t expected_pixels[$];
    int     mismatches;

    function void reset_regs();
        focal_x = 65536; focal_y = 65536; center_x = 0; center_y = 0;
        k1 = 0; k2 = 0; k3 = 0; k4 = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] val);
        case (idx)
            fpj_pkg::REG_FOCAL_X:  focal_x  = longint'({33'b0, val[30:0]});
            fpj_pkg::REG_FOCAL_Y:  focal_y  = longint'({33'b0, val[30:0]});
            fpj_pkg::REG_CENTER_X: center_x = longint'($signed(val));
            fpj_pkg::REG_CENTER_Y: center_y = longint'($signed(val));
            fpj_pkg::REG_COEF_K1:  k1 = longint'($signed(val));
            fpj_pkg::REG_COEF_K2:  k2 = longint'($signed(val));
            fpj_pkg::REG_COEF_K3:  k3 = longint'($signed(val));
            fpj_pkg::REG_COEF_K4:  k4 = longint'($signed(val));
            default: ;
        endcase
    endfunction

    // a*b >> sh, truncated toward zero, magnitude capped at 2^63-1
    function longint scale_mul(longint a, longint b, int sh);
        logic        neg;
        logic [63:0] ua, ub;
        logic [127:0] prod;
        neg  = (a < 0) != (b < 0);
        ua   = a < 0 ? 64'(-a) : 64'(a);
        ub   = b < 0 ? 64'(-b) : 64'(b);
        prod = ({64'b0, ua} * {64'b0, ub}) >> sh;
        if (prod > 128'h7FFF_FFFF_FFFF_FFFF)
            prod = 128'h7FFF_FFFF_FFFF_FFFF;
        return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function longint radial_root(logic [63:0] val);
        logic [63:0] root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > val)
            bitv >>= 2;
        while (bitv != 0) begin
            if (val >= root + bitv) begin
                val  = val - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv >>= 2;
        end
        return longint'(root);
    endfunction

    function longint incidence_angle(longint z, longint rho);
        longint cx_, cy_, ang, base, dx, dy;
        ang = 0;
        base = 0;
        if (z < 0) begin
            cx_ = rho; cy_ = -z; base = 1686629713;
        end else begin
            cx_ = z; cy_ = rho;
        end
        if (cx_ == 0 && cy_ == 0)
            return 0;
        while ((cx_ > cy_ ? cx_ : cy_) < (64'sd1 <<< 59)) begin
            cx_ = cx_ <<< 1;
            cy_ = cy_ <<< 1;
        end
        for (int i = 0; i < 32; i++) begin
            dx = cy_ >>> i;
            dy = cx_ >>> i;
            if (cy_ >= 0) begin
                cx_ += dx; cy_ -= dy; ang += longint'(fpj_pkg::atan_entry(5'(i)));
            end else begin
                cx_ -= dx; cy_ += dy; ang -= longint'(fpj_pkg::atan_entry(5'(i)));
            end
        end
        return base + ang;
    endfunction

    function logic signed [31:0] clip(longint val, inout logic sat);
        if (val > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (val < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return val[31:0];
    endfunction

    function pixel_t project_point(logic signed [31:0] px, logic signed [31:0] py,
                                   logic signed [31:0] pz);
        longint      x, y, z, rho, theta, t2, a, p, r, c, s, u, v;
        logic [63:0] mx, my;
        pixel_t      pix;
        x = px; y = py; z = pz;
        mx = x < 0 ? 64'(-x) : 64'(x);
        my = y < 0 ? 64'(-y) : 64'(y);
        rho   = radial_root(mx * mx + my * my);
        theta = incidence_angle(z, rho);
        t2    = scale_mul(theta, theta, 30);
        a = k4;
        a = k3 + scale_mul(a, t2, 30);
        a = k2 + scale_mul(a, t2, 30);
        a = k1 + scale_mul(a, t2, 30);
        p = scale_mul(a, t2, 30);
        r = theta + scale_mul(theta, p, 24);
        if (rho == 0) begin
            c = 64'sd1073741824;
            s = 0;
        end else begin
            c = longint'((mx << 30) / 64'(rho));
            s = longint'((my << 30) / 64'(rho));
            if (x < 0) c = -c;
            if (y < 0) s = -s;
        end
        u = center_x + scale_mul(scale_mul(focal_x, c, 30), r, 30);
        v = center_y + scale_mul(scale_mul(focal_y, s, 30), r, 30);
        pix.sat = 1'b0;
        pix.u = clip(u, pix.sat);
        pix.v = clip(v, pix.sat);
        return pix;
    endfunction

    function void note_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
        expected_pixels.push_back(project_point(x, y, z));
    endfunction

    function void check_pixel(logic signed [31:0] u, logic signed [31:0] v, logic sat);
        pixel_t e;
        if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected pixel u=%0d v=%0d sat=%0b", u, v, sat);
            return;
        end
        e = expected_pixels.pop_front();
        if (e.u !== u || e.v !== v || e.sat !== sat) begin
            mismatches++;
            if (mismatches <= 10)
                $display("pixel mismatch: exp u=%0d v=%0d sat=%0b, got u=%0d v=%0d sat=%0b",
                         e.u, e.v, e.sat, u, v, sat);
        end
    endfunction

endclass

module tb_fisheye_forward_projection;
    import fpj_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 150;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [95:0]          s_tdata;    // point_x, point_y, point_z
    logic                 m_tvalid;
    logic                 m_tready;
    logic [63:0]          m_tdata;    // pixel_u, pixel_v
    logic                 m_tuser;    // saturated
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [31:0]          cfg_wdata;

    pixel_scoreboard sb;
    bit              quiet;       // no idling in the closing phase
    int              stall_cycles;

    fisheye_forward_projection DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // sink side: random stall bursts until the quiet phase
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // result check and stall watchdog
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_pixel(m_tdata[31:0], m_tdata[63:32], m_tuser);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_lens(input logic [31:0] fx, fy, cx, cy, c1, c2, c3, c4);
        write_reg(REG_FOCAL_X, fx);
        write_reg(REG_FOCAL_Y, fy);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_COEF_K1, c1);
        write_reg(REG_COEF_K2, c2);
        write_reg(REG_COEF_K3, c3);
        write_reg(REG_COEF_K4, c4);
        // out-of-range index must be ignored
        write_reg(CFG_IDX_W'($urandom_range(8, 255)), $urandom);
    endtask

    task automatic send_point(input logic signed [31:0] x, y, z);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 10) - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {z, y, x};
        do @(posedge aclk); while (!s_tready);
        sb.note_point(x, y, z);
    endtask

    // hold the input off and let the pipe empty
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic random_points(input int count);
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)       // in front of a lens, moderate field
                send_point($urandom_range(0, 32'h0100_0000) - 32'h0080_0000,
                           $urandom_range(0, 32'h0100_0000) - 32'h0080_0000,
                           $urandom_range(1, 32'h0080_0000));
            else if (kind == 6)  // anything
                send_point($urandom, $urandom, $urandom);
            else if (kind == 7)  // behind the camera
                send_point($urandom, $urandom, -$signed(32'($urandom_range(1, 32'h7FFF_FFFF))));
            else if (kind == 8)  // on the optical axis
                send_point(0, 0, $urandom);
            else                 // tiny values near the origin
                send_point($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
                           $urandom_range(0, 8) - 4);
        end
    endtask

    initial begin
        sb = new();
        sb.reset_regs();
        quiet        = 1'b0;
        stall_cycles = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset calibration: corner points and special cases
        send_point(0, 0, 0);                               // all zero
        send_point(0, 0, 32'sh0001_0000);                  // axis, forward
        send_point(0, 0, -32'sh0001_0000);                 // axis, backward
        send_point(0, 0, 32'sh8000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 0);
        send_point(32'sh0001_0000, 0, 0);                  // 90 degrees
        send_point(0, -32'sh0001_0000, -1);
        send_point(1, -1, 1);
        send_point(-1, 1, -1);
        send_point(32'sh7FFF_FFFF, 0, -32'sh8000_0000);
        drain();

        // typical wide-angle lens, far from saturation
        load_lens(300 << 16, 300 << 16, 640 << 16, 480 << 16,
                  32'h0001_99A0, -32'sh0000_A3D7, 32'h0000_20C5, -32'sh0000_0831);
        send_point(0, 0, 0);
        send_point(0, 0, -32'sh0002_0000);
        send_point(32'sh0002_0000, -32'sh0001_0000, 32'sh0004_0000);
        random_points(300);
        drain();

        // register extremes, focal written with its unused top bit set
        load_lens(32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        send_point(0, 0, 0);
        send_point(0, 0, -1);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001);
        random_points(150);
        drain();

        load_lens(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        random_points(100);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            load_lens($urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
            random_points(100);
            drain();
        end

        // closing phase without idling on either side
        load_lens(500 << 16, 480 << 16, -32'sh0010_0000, 32'sh0200_0000,
                  32'h0000_8000, 32'h0000_1000, -32'sh0000_0400, 32'h0000_0080);
        quiet = 1'b1;
        random_points(200);
        drain();

        if (sb.mismatches == 0 && sb.expected_pixels.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/fpj_pkg.sv
rtl/core/fpj_mul.sv
rtl/core/fpj_isqrt.sv
rtl/core/fpj_angle.sv
rtl/core/fisheye_forward_projection.sv
rtl/core/fpj_check.sv
bench/tb_fisheye_forward_projection.sv
